>>> rtl/qsu_pkg.sv
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, codes and helper functions for the quoted string unescape
// decoder.
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam int UnitWidth = 16;
   localparam int AccWidth  = 32;

   localparam logic [2:0] PH_OPEN   = 3'd0;
   localparam logic [2:0] PH_BODY   = 3'd1;
   localparam logic [2:0] PH_ESC    = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;

   localparam logic [1:0] KIND_HEX2 = 2'd0;
   localparam logic [1:0] KIND_HEX4 = 2'd1;
   localparam logic [1:0] KIND_HEX8 = 2'd2;
   localparam logic [1:0] KIND_OCT  = 2'd3;

   localparam logic [UnitWidth-1:0] CHAR_QUOTE     = 16'h0022;
   localparam logic [UnitWidth-1:0] CHAR_BACKSLASH = 16'h005C;
   localparam logic [UnitWidth-1:0] CHAR_ZERO      = 16'h0030;
   localparam logic [UnitWidth-1:0] CHAR_SEVEN     = 16'h0037;
   localparam logic [UnitWidth-1:0] CHAR_NINE      = 16'h0039;
   localparam logic [UnitWidth-1:0] CHAR_LOW_A     = 16'h0061;
   localparam logic [UnitWidth-1:0] CHAR_LOW_B     = 16'h0062;
   localparam logic [UnitWidth-1:0] CHAR_LOW_F     = 16'h0066;
   localparam logic [UnitWidth-1:0] CHAR_LOW_N     = 16'h006E;
   localparam logic [UnitWidth-1:0] CHAR_LOW_R     = 16'h0072;
   localparam logic [UnitWidth-1:0] CHAR_LOW_T     = 16'h0074;
   localparam logic [UnitWidth-1:0] CHAR_LOW_U     = 16'h0075;
   localparam logic [UnitWidth-1:0] CHAR_LOW_V     = 16'h0076;
   localparam logic [UnitWidth-1:0] CHAR_LOW_X     = 16'h0078;
   localparam logic [UnitWidth-1:0] CHAR_UP_A      = 16'h0041;
   localparam logic [UnitWidth-1:0] CHAR_UP_F      = 16'h0046;
   localparam logic [UnitWidth-1:0] CHAR_UP_U      = 16'h0055;

   localparam logic [UnitWidth-1:0] CODE_BELL      = 16'h0007;
   localparam logic [UnitWidth-1:0] CODE_BACKSPACE = 16'h0008;
   localparam logic [UnitWidth-1:0] CODE_TAB       = 16'h0009;
   localparam logic [UnitWidth-1:0] CODE_NEWLINE   = 16'h000A;
   localparam logic [UnitWidth-1:0] CODE_VTAB      = 16'h000B;
   localparam logic [UnitWidth-1:0] CODE_FORMFEED  = 16'h000C;
   localparam logic [UnitWidth-1:0] CODE_RETURN    = 16'h000D;

   localparam logic [AccWidth-1:0] MAX_CODE_POINT = 32'h0010_FFFF;
   localparam logic [AccWidth-1:0] MAX_BMP        = 32'h0000_FFFF;
   localparam logic [AccWidth-1:0] MAX_OCTAL      = 32'h0000_00FF;
   localparam logic [20:0]         SUPP_BASE      = 21'h01_0000;
   localparam logic [UnitWidth-1:0] HIGH_SURR     = 16'hD800;
   localparam logic [UnitWidth-1:0] LOW_SURR      = 16'hDC00;

   typedef struct packed {
      logic [2:0]          parse_phase;
      logic [1:0]          escape_kind;
      logic [3:0]          digits_left;
      logic [AccWidth-1:0] code_accumulator;
      logic                failed_flag;
   } qsu_state_type;

   localparam qsu_state_type STATE_RESET = '{
      parse_phase:      PH_OPEN,
      escape_kind:      KIND_HEX2,
      digits_left:      4'd0,
      code_accumulator: '0,
      failed_flag:      1'b0
   };

   typedef struct packed {
      logic [UnitWidth-1:0] decoded_unit;
      logic                 run_last;
      logic                 string_end;
      logic                 syntax_error;
   } qsu_item_type;

   // Results produced by one accepted item: zero, one or two.
   typedef struct packed {
      logic [1:0]   count;
      qsu_item_type item0;
      qsu_item_type item1;
   } qsu_push_type;

   // Returns {valid, digit} for a hexadecimal digit character.
   function automatic logic [4:0] hex_digit(input logic [UnitWidth-1:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         res = {1'b1, c[3:0]};
      end else if (c inside {[CHAR_LOW_A:CHAR_LOW_F], [CHAR_UP_A:CHAR_UP_F]}) begin
         res = {1'b1, c[3:0] + 4'd9};
      end
      return res;
   endfunction

   function automatic logic is_octal(input logic [UnitWidth-1:0] c);
      return c inside {[CHAR_ZERO:CHAR_SEVEN]};
   endfunction

endpackage

>>> rtl/qsu_if.sv
// ----------------------------------------------------------------------------
// qsu_req_if / qsu_rsp_if
// Valid/ready channels carrying input code units and decoded result items.
// ----------------------------------------------------------------------------
interface qsu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        string_last;

   modport source (output valid, output code_unit, output string_last, input ready);
   modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface qsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] decoded_unit;
   logic        run_last;
   logic        string_end;
   logic        syntax_error;

   modport source (output valid, output decoded_unit, output run_last,
                   output string_end, output syntax_error, input ready);
   modport sink   (input valid, input decoded_unit, input run_last,
                   input string_end, input syntax_error, output ready);
endinterface

>>> rtl/qsu_parser.sv
// ----------------------------------------------------------------------------
// qsu_parser
// Parse state registers and the single-pass decode of one code unit into
// up to two result items.
// ----------------------------------------------------------------------------
module qsu_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [qsu_pkg::UnitWidth-1:0]  code_unit,
   input  logic                           string_last,
   output qsu_pkg::qsu_push_type          push
);
   import qsu_pkg::*;

   qsu_state_type state_ff;
   qsu_state_type state_in;

   logic [4:0]          hex_res;
   logic                digit_ok;
   logic [AccWidth-1:0] acc_next;
   logic [3:0]          digits_next;
   logic [20:0]         supp_off;
   logic                out_of_range;

   always_comb begin
      hex_res      = hex_digit(code_unit);
      digit_ok     = (state_ff.escape_kind == KIND_OCT) ? is_octal(code_unit) : hex_res[4];
      acc_next     = (state_ff.escape_kind == KIND_OCT) ?
                     {state_ff.code_accumulator[AccWidth-4:0], code_unit[2:0]} :
                     {state_ff.code_accumulator[AccWidth-5:0], hex_res[3:0]};
      digits_next  = state_ff.digits_left - 4'd1;
      out_of_range = ((state_ff.escape_kind == KIND_HEX8) && (acc_next > MAX_CODE_POINT)) ||
                     ((state_ff.escape_kind == KIND_OCT) && (acc_next > MAX_OCTAL));
      supp_off     = acc_next[20:0] - SUPP_BASE;

      state_in = state_ff;
      push     = '0;

      if (string_last) begin
         push.count              = 2'd1;
         push.item0.string_end   = 1'b1;
         push.item0.syntax_error = !(!state_ff.failed_flag &&
                                     (state_ff.parse_phase == PH_BODY) &&
                                     (code_unit == CHAR_QUOTE));
         state_in = STATE_RESET;
      end else if (!state_ff.failed_flag) begin
         case (state_ff.parse_phase)
            PH_OPEN: begin
               state_in.failed_flag = (code_unit != CHAR_QUOTE);
               state_in.parse_phase = PH_BODY;
            end
            PH_BODY: begin
               if (code_unit == CHAR_BACKSLASH) begin
                  state_in.parse_phase = PH_ESC;
               end else begin
                  push.count              = 2'd1;
                  push.item0.decoded_unit = code_unit;
               end
            end
            PH_ESC: begin
               state_in.parse_phase = PH_BODY;
               push.count           = 2'd1;
               case (code_unit)
                  CHAR_LOW_A:     push.item0.decoded_unit = CODE_BELL;
                  CHAR_LOW_B:     push.item0.decoded_unit = CODE_BACKSPACE;
                  CHAR_LOW_F:     push.item0.decoded_unit = CODE_FORMFEED;
                  CHAR_LOW_N:     push.item0.decoded_unit = CODE_NEWLINE;
                  CHAR_LOW_R:     push.item0.decoded_unit = CODE_RETURN;
                  CHAR_LOW_T:     push.item0.decoded_unit = CODE_TAB;
                  CHAR_LOW_V:     push.item0.decoded_unit = CODE_VTAB;
                  CHAR_BACKSLASH: push.item0.decoded_unit = CHAR_BACKSLASH;
                  CHAR_QUOTE:     push.item0.decoded_unit = CHAR_QUOTE;
                  CHAR_LOW_X: begin
                     push.count                 = 2'd0;
                     state_in.escape_kind       = KIND_HEX2;
                     state_in.digits_left       = 4'd2;
                     state_in.code_accumulator  = '0;
                     state_in.parse_phase       = PH_DIGITS;
                  end
                  CHAR_LOW_U: begin
                     push.count                 = 2'd0;
                     state_in.escape_kind       = KIND_HEX4;
                     state_in.digits_left       = 4'd4;
                     state_in.code_accumulator  = '0;
                     state_in.parse_phase       = PH_DIGITS;
                  end
                  CHAR_UP_U: begin
                     push.count                 = 2'd0;
                     state_in.escape_kind       = KIND_HEX8;
                     state_in.digits_left       = 4'd8;
                     state_in.code_accumulator  = '0;
                     state_in.parse_phase       = PH_DIGITS;
                  end
                  default: begin
                     push.count = 2'd0;
                     if (is_octal(code_unit)) begin
                        state_in.escape_kind      = KIND_OCT;
                        state_in.digits_left      = 4'd2;
                        state_in.code_accumulator = {{(AccWidth-3){1'b0}}, code_unit[2:0]};
                        state_in.parse_phase      = PH_DIGITS;
                     end else begin
                        state_in.failed_flag = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               if (!digit_ok) begin
                  state_in.failed_flag = 1'b1;
                  state_in.parse_phase = PH_BODY;
               end else begin
                  state_in.code_accumulator = acc_next;
                  state_in.digits_left      = digits_next;
                  if (digits_next == 4'd0) begin
                     state_in.parse_phase = PH_BODY;
                     if (out_of_range) begin
                        state_in.failed_flag = 1'b1;
                     end else if (acc_next > MAX_BMP) begin
                        push.count              = 2'd2;
                        push.item0.decoded_unit = HIGH_SURR + {6'd0, supp_off[19:10]};
                        push.item1.decoded_unit = LOW_SURR + {6'd0, supp_off[9:0]};
                     end else begin
                        push.count              = 2'd1;
                        push.item0.decoded_unit = acc_next[UnitWidth-1:0];
                     end
                  end
               end
            end
         endcase
      end

      push.item0.run_last = (push.count == 2'd1);
      push.item1.run_last = (push.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("parser result count out of range");
   a_end_single: assert property (@(posedge clock) disable iff (reset)
      string_last |-> (push.count == 2'd1) && push.item0.string_end && push.item0.run_last)
      else $error("final unit must give exactly one status item");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && string_last) |=> (state_ff.parse_phase == PH_OPEN) && !state_ff.failed_flag)
      else $error("parse state not cleared after final unit");
   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff.failed_flag && !string_last) |-> (push.count == 2'd0))
      else $error("results emitted after a syntax error");
`endif

endmodule

>>> rtl/qsu_out_buf.sv
// ----------------------------------------------------------------------------
// qsu_out_buf
// Two-entry result register that hands decoded items to rsp one per cycle
// while rsp.ready is high and tells the input side when a new item may enter.
// ----------------------------------------------------------------------------
module qsu_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  qsu_pkg::qsu_push_type push,
   output logic                  can_accept,
   qsu_rsp_if.source             rsp
);
   import qsu_pkg::*;

   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   qsu_item_type slot0_ff;
   qsu_item_type slot0_in;
   qsu_item_type slot1_ff;
   qsu_item_type slot1_in;
   logic         pop;

   assign pop        = rsp.valid && rsp.ready;
   assign can_accept = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp.ready);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push_en) begin
         count_in = push.count;
         slot0_in = push.item0;
         slot1_in = push.item1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.decoded_unit = slot0_ff.decoded_unit;
   assign rsp.run_last     = slot0_ff.run_last;
   assign rsp.string_end   = slot0_ff.string_end;
   assign rsp.syntax_error = slot0_ff.syntax_error;

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overfilled");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_en |-> (count_ff == 2'd0) || ((count_ff == 2'd1) && pop))
      else $error("item pushed over pending results");
   a_pair_holds: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd2) && !pop) |=> (count_ff == 2'd2) && $stable(slot0_ff))
      else $error("stalled result pair changed");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd2) && pop) |=> (count_ff == 2'd1) && (slot0_ff == $past(slot1_ff)))
      else $error("second result of a pair lost");
`endif

endmodule

>>> rtl/quoted_string_unescape_decoder_top.sv
// ----------------------------------------------------------------------------
// quoted_string_unescape_decoder_top
// Streaming decoder for a double-quoted string literal with escapes.
// ----------------------------------------------------------------------------
// The block takes one UTF-16 code unit per cycle on req while ready is high
// and returns decoded units on rsp in the cycle after the unit is taken.
// Most units give zero or one item and flow at one item per cycle while rsp
// is ready; a \U escape above 0xFFFF gives a surrogate pair, which holds the
// result port for both items and the input until the first is taken, in the
// two-entry result register. The final unit of each literal gives one status
// item that reports success or invalid syntax and returns the parser to start.
module quoted_string_unescape_decoder_top (
   input  logic      clock,
   input  logic      reset,
   qsu_req_if.sink   req,
   qsu_rsp_if.source rsp
);
   import qsu_pkg::*;

   logic         can_accept;
   logic         accept;
   qsu_push_type push;

   assign req.ready = can_accept;
   assign accept    = req.valid && can_accept;

   qsu_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .code_unit   (req.code_unit),
      .string_last (req.string_last),
      .push        (push)
   );

   qsu_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push       (push),
      .can_accept (can_accept),
      .rsp        (rsp)
   );

endmodule
